>>> rtl/spl_pkg.sv
package spl_pkg;

  // Fixed widths of the item fields at the ports.
  localparam int FIELD_W = 32;
  localparam int SUM_W   = 38;
  localparam int LVL_W   = 7;

  // Command codes carried by func_i.
  localparam logic [1:0] FN_ADD    = 2'd0;
  localparam logic [1:0] FN_REMOVE = 2'd1;
  localparam logic [1:0] FN_GET    = 2'd2;
  localparam logic [1:0] FN_TOP    = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND  = 2'd1;
  localparam logic [1:0] ST_NOT_ENOUGH = 2'd2;
  localparam logic [1:0] ST_FULL       = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;
    logic       insert;
    logic       update;
    logic       remove;
    logic       rotate;
    logic       load_out;
    logic [1:0] status;
    logic       row_get;
    logic       row_top;
    logic       last;
  } spl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic found;
    logic full;
    logic out_free;
  } spl_sts_t;

endpackage

>>> rtl/spl_datapath.sv
module spl_datapath import spl_pkg::*; #(
  parameter int DEPTH        = 64,
  parameter int PRICE_WIDTH  = 32,
  parameter int AMOUNT_WIDTH = 32,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spl_cmd_t            cmd_i,
  output spl_sts_t            sts_o,
  output logic [CW-1:0]       n_o,
  input  logic [FIELD_W-1:0]  price_i,
  input  logic [FIELD_W-1:0]  amount_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [1:0]          status_o,
  output logic                row_valid_o,
  output logic [FIELD_W-1:0]  row_price_o,
  output logic [FIELD_W-1:0]  row_amount_o,
  output logic [SUM_W-1:0]    sum_amount_o,
  output logic [LVL_W-1:0]    level_count_o,
  output logic                last_o
);

  // Prices and amounts above the port width can never be seen.
  localparam int PW = (PRICE_WIDTH < FIELD_W) ? PRICE_WIDTH : FIELD_W;
  localparam int AW = (AMOUNT_WIDTH < FIELD_W) ? AMOUNT_WIDTH : FIELD_W;

  logic [PW-1:0]    price_q [DEPTH];
  logic [PW-1:0]    price_d [DEPTH];
  logic [AW-1:0]    amt_q   [DEPTH];
  logic [AW-1:0]    amt_d   [DEPTH];
  logic [DEPTH-1:0] gt_q, gt_d;
  logic [DEPTH-1:0] eq_q, eq_d;
  logic [PW-1:0]    p_q;
  logic [AW-1:0]    a_q;
  logic [CW-1:0]    n_q, n_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [AW-1:0]    old_amt;
  logic [PW-1:0]    pin;

  logic                out_valid_q;
  logic [1:0]          status_q;
  logic                row_valid_q;
  logic [FIELD_W-1:0]  row_price_q;
  logic [FIELD_W-1:0]  row_amount_q;
  logic [SUM_W-1:0]    sum_out_q;
  logic [LVL_W-1:0]    lvl_out_q;
  logic                last_q;

  assign pin = price_i[PW-1:0];

  // Every entry compares itself with the incoming price and moves on its own.
  // The table is kept in descending order, so the entries above the new price
  // form a prefix and the rest shift by one place.
  for (genvar g = 0; g < DEPTH; g++) begin : g_entry
    always_comb begin
      gt_d[g] = (CW'(g) < n_q) && (price_q[g] > pin);
      eq_d[g] = (CW'(g) < n_q) && (price_q[g] == pin);
    end

    always_comb begin
      price_d[g] = price_q[g];
      amt_d[g]   = amt_q[g];
      if (cmd_i.insert && !gt_q[g]) begin
        if (g == 0) begin
          price_d[g] = p_q;
          amt_d[g]   = a_q;
        end else if (gt_q[(g > 0) ? g - 1 : 0]) begin
          price_d[g] = p_q;
          amt_d[g]   = a_q;
        end else begin
          price_d[g] = price_q[(g > 0) ? g - 1 : 0];
          amt_d[g]   = amt_q[(g > 0) ? g - 1 : 0];
        end
      end
      if (cmd_i.update && eq_q[g]) begin
        amt_d[g] = a_q;
      end
      if (cmd_i.remove && !gt_q[g] && (g < DEPTH - 1)) begin
        price_d[g] = price_q[(g < DEPTH - 1) ? g + 1 : g];
        amt_d[g]   = amt_q[(g < DEPTH - 1) ? g + 1 : g];
      end
      // Rotation moves every stored level up one place, the head going to the tail.
      if (cmd_i.rotate && (CW'(g) < n_q)) begin
        if (CW'(g + 1) == n_q) begin
          price_d[g] = price_q[0];
          amt_d[g]   = amt_q[0];
        end else begin
          price_d[g] = price_q[(g < DEPTH - 1) ? g + 1 : g];
          amt_d[g]   = amt_q[(g < DEPTH - 1) ? g + 1 : g];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      price_q[g] <= price_d[g];
      amt_q[g]   <= amt_d[g];
    end
  end

  always_comb begin
    old_amt = '0;
    for (int i = 0; i < DEPTH; i++) begin
      old_amt = old_amt | (eq_q[i] ? amt_q[i] : '0);
    end
  end

  always_comb begin
    n_d   = n_q;
    sum_d = sum_q;
    if (cmd_i.insert) begin
      n_d   = n_q + CW'(1);
      sum_d = sum_q + SUM_W'(a_q);
    end else if (cmd_i.update) begin
      sum_d = sum_q - SUM_W'(old_amt) + SUM_W'(a_q);
    end else if (cmd_i.remove) begin
      n_d   = n_q - CW'(1);
      sum_d = sum_q - SUM_W'(old_amt);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      gt_q <= gt_d;
      eq_q <= eq_d;
      p_q  <= pin;
      a_q  <= amount_i[AW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q         <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      n_q   <= n_d;
      sum_q <= sum_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      status_q    <= cmd_i.status;
      row_valid_q <= cmd_i.row_get || cmd_i.row_top;
      last_q      <= cmd_i.last;
      sum_out_q   <= sum_d;
      lvl_out_q   <= LVL_W'(n_d);
      if (cmd_i.row_get) begin
        row_price_q  <= FIELD_W'(p_q);
        row_amount_q <= FIELD_W'(old_amt);
      end else if (cmd_i.row_top) begin
        row_price_q  <= FIELD_W'(price_q[0]);
        row_amount_q <= FIELD_W'(amt_q[0]);
      end else begin
        row_price_q  <= '0;
        row_amount_q <= '0;
      end
    end
  end

  assign sts_o.found    = |eq_q;
  assign sts_o.full     = (n_q == CW'(DEPTH));
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign n_o            = n_q;

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign row_valid_o   = row_valid_q;
  assign row_price_o   = row_price_q;
  assign row_amount_o  = row_amount_q;
  assign sum_amount_o  = sum_out_q;
  assign level_count_o = lvl_out_q;
  assign last_o        = last_q;

endmodule

>>> rtl/spl_ctrl.sv
module spl_ctrl import spl_pkg::*; #(
  parameter int DEPTH = 64,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       func_i,
  input  logic [LVL_W-1:0] count_i,
  input  spl_sts_t         sts_i,
  input  logic [CW-1:0]    n_i,
  output spl_cmd_t         cmd_o
);

  localparam int CMPW = (CW > LVL_W) ? CW : LVL_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_ROT  = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CW-1:0]    k_q, k_d;
  logic [1:0]       func_q;
  logic [LVL_W-1:0] cnt_q;
  logic [CMPW-1:0]  cnt_ext, n_ext, k_ext;
  logic             emit;

  assign cnt_ext = CMPW'(cnt_q);
  assign n_ext   = CMPW'(n_i);
  assign k_ext   = CMPW'(k_q);
  assign emit    = k_ext < cnt_ext;

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        if (func_q == FN_TOP && cnt_ext <= n_ext && cnt_q != '0) begin
          k_d     = '0;
          state_d = S_ROT;
        end else if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.last     = 1'b1;
          state_d        = S_IDLE;
          case (func_q)
            FN_ADD: begin
              if (sts_i.found) begin
                cmd_o.update = 1'b1;
                cmd_o.status = ST_OK;
              end else if (sts_i.full) begin
                cmd_o.status = ST_FULL;
              end else begin
                cmd_o.insert = 1'b1;
                cmd_o.status = ST_OK;
              end
            end
            FN_REMOVE: begin
              cmd_o.remove = sts_i.found;
              cmd_o.status = sts_i.found ? ST_OK : ST_NOT_FOUND;
            end
            FN_GET: begin
              cmd_o.row_get = sts_i.found;
              cmd_o.status  = sts_i.found ? ST_OK : ST_NOT_FOUND;
            end
            FN_TOP: begin
              cmd_o.status = (cnt_ext > n_ext) ? ST_NOT_ENOUGH : ST_OK;
            end
            default: begin
              cmd_o.status = ST_OK;
            end
          endcase
        end
      end
      S_ROT: begin
        // The head entry is shown while fewer than count levels have gone out, and is
        // sent to the tail; after all stored levels have gone round once the table is back in its own order.
        if (!emit || sts_i.out_free) begin
          cmd_o.rotate = 1'b1;
          if (emit) begin
            cmd_o.load_out = 1'b1;
            cmd_o.row_top  = 1'b1;
            cmd_o.status   = ST_OK;
            cmd_o.last     = (k_ext + CMPW'(1)) == cnt_ext;
          end
          if ((k_q + CW'(1)) == n_i) begin
            state_d = S_IDLE;
          end else begin
            k_d = k_q + CW'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_o.capture) begin
      func_q <= func_i;
      cnt_q  <= count_i;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

>>> rtl/sorted_price_level_table.sv
// Sorted price level table. Up to DEPTH levels are held in registers in
// descending price order, with a running 38-bit sum of the amounts and a count
// of levels. Every stored price is compared with an accepted item's price at
// once and the result is registered; then, once the output register is free,
// the table shifts by one place (add of a new price when not full, removal),
// updates an amount in place (add of a stored price) or is read, giving one
// result. For a top-levels item with a count from one up to the number of
// stored levels N, the levels are rotated through entry zero one per cycle,
// save where a level to be shown waits for the output register; the first
// count of them are shown as results, and the full turn leaves the table in
// its original order. A waiting result stalls only the cycle that would
// overwrite it; a new item is taken while the previous one's result waits.
module sorted_price_level_table import spl_pkg::*; #(
  parameter int DEPTH        = 64,
  parameter int PRICE_WIDTH  = 32,
  parameter int AMOUNT_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          func_i,
  input  logic [FIELD_W-1:0]  price_i,
  input  logic [FIELD_W-1:0]  amount_i,
  input  logic [LVL_W-1:0]    count_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          status_o,
  output logic                row_valid_o,
  output logic [FIELD_W-1:0]  row_price_o,
  output logic [FIELD_W-1:0]  row_amount_o,
  output logic [SUM_W-1:0]    sum_amount_o,
  output logic [LVL_W-1:0]    level_count_o,
  output logic                last_o
);

  localparam int CW = $clog2(DEPTH + 1);

  spl_cmd_t      cmd;
  spl_sts_t      sts;
  logic [CW-1:0] n;

  spl_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .count_i    (count_i),
    .sts_i      (sts),
    .n_i        (n),
    .cmd_o      (cmd)
  );

  spl_datapath #(
    .DEPTH        (DEPTH),
    .PRICE_WIDTH  (PRICE_WIDTH),
    .AMOUNT_WIDTH (AMOUNT_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .n_o           (n),
    .price_i       (price_i),
    .amount_i      (amount_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .status_o      (status_o),
    .row_valid_o   (row_valid_o),
    .row_price_o   (row_price_o),
    .row_amount_o  (row_amount_o),
    .sum_amount_o  (sum_amount_o),
    .level_count_o (level_count_o),
    .last_o        (last_o)
  );

endmodule
